FILE: rtl/assert_macros.svh
// Assertion macros shared by the sparse interval diff encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sidenc_pkg.sv
// Types and constants shared by the sparse interval diff encoder.
`timescale 1ns / 1ps

package sidenc_pkg;

   // Field widths.
   localparam int INDEX_W    = 20;
   localparam int WORD_W     = 32;
   localparam int ADDR_W     = 22;
   localparam int RUN_W      = 17;
   localparam int GAP_W      = 16;
   localparam int BLOCK_BITS = 4;

   // Register reset value of the gap window.
   localparam logic [GAP_W-1:0] GAP_RESET = 16'd32;

   // Result bundle sizing: up to four results per item.
   localparam int MAX_RESULTS = 4;
   localparam int POS_W       = 2;
   localparam int CNT_W       = 3;

   // Stream data widths, padded to whole bytes.
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 56;

   // Interval state.
   typedef enum logic [1:0] {
      MODE_SCAN = 2'd0,
      MODE_OPEN = 2'd1,
      MODE_COPY = 2'd2
   } mode_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_LENGTH = 2'd2
   } kind_type;

   // One input item.
   typedef struct packed {
      logic                 last_word;
      logic [WORD_W-1:0]    old_word;
      logic [WORD_W-1:0]    new_word;
      logic [INDEX_W-1:0]   word_index;
   } item_type;

   // One result item (last_of_item is derived from its place in the bundle).
   typedef struct packed {
      kind_type             kind;
      logic [ADDR_W-1:0]    write_address;
      logic [WORD_W-1:0]    write_value;
   } res_type;

   // All results caused by one item, packed from slot zero up.
   typedef struct packed {
      logic [CNT_W-1:0]             count;
      res_type [MAX_RESULTS-1:0]    slot;
   } bundle_type;

endpackage

FILE: rtl/sidenc_core.sv
// Interval state and the per-item result computation of the diff encoder.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sidenc_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [sidenc_pkg::GAP_W-1:0]      gap_window,
   input  sidenc_pkg::item_type              item,
   output sidenc_pkg::bundle_type            bundle
);

   // State registers.
   sidenc_pkg::mode_type                  mode_ff, mode_in;
   logic [sidenc_pkg::RUN_W-1:0]          run_ff, run_in;
   logic [sidenc_pkg::ADDR_W-1:0]         wp_ff, wp_in;
   logic [sidenc_pkg::ADDR_W-1:0]         hs_ff, hs_in;

   // Intermediate values after the word itself is handled.
   sidenc_pkg::mode_type                  mode1;
   logic [sidenc_pkg::RUN_W-1:0]          run1;
   logic [sidenc_pkg::ADDR_W-1:0]         wp1;
   logic [sidenc_pkg::ADDR_W-1:0]         hs1;
   logic [sidenc_pkg::ADDR_W-1:0]         data_addr;
   logic                                  open_now;
   logic                                  copy_now;

   // Closing decisions.
   logic                                  changed;
   logic                                  boundary;
   logic                                  end_hdr_v;
   logic                                  retract;
   logic [sidenc_pkg::ADDR_W-1:0]         wp2;
   logic [sidenc_pkg::WORD_W-1:0]         end_base;
   logic [sidenc_pkg::WORD_W-1:0]         end_value;

   assign changed  = item.new_word != item.old_word;
   assign boundary = &item.word_index[sidenc_pkg::BLOCK_BITS-1:0];
   assign end_base = sidenc_pkg::WORD_W'(item.word_index) + sidenc_pkg::WORD_W'(1);

   // Handle the word: open an interval at a change, or copy while open.
   always_comb begin
      mode1     = mode_ff;
      run1      = run_ff;
      wp1       = wp_ff;
      hs1       = hs_ff;
      data_addr = wp_ff;
      open_now  = 1'b0;
      copy_now  = 1'b0;
      case (mode_ff)
         sidenc_pkg::MODE_SCAN: begin
            if (changed) begin
               open_now  = 1'b1;
               hs1       = wp_ff;
               data_addr = wp_ff + sidenc_pkg::ADDR_W'(2);
               wp1       = wp_ff + sidenc_pkg::ADDR_W'(3);
               run1      = '0;
               mode1     = sidenc_pkg::MODE_OPEN;
            end
         end
         sidenc_pkg::MODE_OPEN, sidenc_pkg::MODE_COPY: begin
            copy_now = 1'b1;
            wp1      = wp_ff + sidenc_pkg::ADDR_W'(1);
            if (changed) begin
               run1 = '0;
            end else if (run_ff != '1) begin
               run1 = run_ff + sidenc_pkg::RUN_W'(1);
            end
         end
         default: begin
            mode1 = sidenc_pkg::MODE_SCAN;
         end
      endcase
   end

   // Decide whether the interval closes here and by how much it retracts.
   always_comb begin
      if (item.last_word) begin
         end_hdr_v = mode1 != sidenc_pkg::MODE_SCAN;
      end else begin
         end_hdr_v = boundary && (mode1 == sidenc_pkg::MODE_COPY) &&
                     (run1 > sidenc_pkg::RUN_W'(gap_window));
      end
      retract   = end_hdr_v && (mode1 == sidenc_pkg::MODE_COPY);
      wp2       = retract ? wp1 - sidenc_pkg::ADDR_W'(run1) : wp1;
      end_value = retract ? end_base - sidenc_pkg::WORD_W'(run1) : end_base;
   end

   // Next state.
   always_comb begin
      mode_in = mode1;
      run_in  = run1;
      wp_in   = wp2;
      hs_in   = hs1;
      if (item.last_word) begin
         mode_in = sidenc_pkg::MODE_SCAN;
         run_in  = '0;
         wp_in   = '0;
         hs_in   = '0;
      end else if (boundary) begin
         case (mode1)
            sidenc_pkg::MODE_OPEN: mode_in = sidenc_pkg::MODE_COPY;
            sidenc_pkg::MODE_COPY: mode_in = end_hdr_v ? sidenc_pkg::MODE_SCAN
                                                       : sidenc_pkg::MODE_COPY;
            default:               mode_in = mode1;
         endcase
      end
   end

   // Results in order: data, start header, end header, length report.
   always_comb begin
      sidenc_pkg::res_type [sidenc_pkg::MAX_RESULTS-1:0] cand;
      logic [sidenc_pkg::MAX_RESULTS-1:0]               cand_v;
      logic [sidenc_pkg::CNT_W-1:0]                     cnt;

      cand[0] = '{kind: sidenc_pkg::KIND_DATA, write_address: data_addr,
                  write_value: item.new_word};
      cand[1] = '{kind: sidenc_pkg::KIND_HEADER, write_address: hs1,
                  write_value: sidenc_pkg::WORD_W'(item.word_index)};
      cand[2] = '{kind: sidenc_pkg::KIND_HEADER,
                  write_address: hs1 + sidenc_pkg::ADDR_W'(1),
                  write_value: end_value};
      cand[3] = '{kind: sidenc_pkg::KIND_LENGTH, write_address: '0,
                  write_value: sidenc_pkg::WORD_W'(wp2)};
      cand_v  = {item.last_word, end_hdr_v, open_now, open_now | copy_now};

      cnt         = '0;
      bundle.slot = '0;
      for (int i = 0; i < sidenc_pkg::MAX_RESULTS; i++) begin
         if (cand_v[i]) begin
            bundle.slot[cnt[sidenc_pkg::POS_W-1:0]] = cand[i];
            cnt = cnt + sidenc_pkg::CNT_W'(1);
         end
      end
      bundle.count = cnt;
   end

   // State update, one step per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sidenc_pkg::MODE_SCAN;
         run_ff  <= '0;
         wp_ff   <= '0;
         hs_ff   <= '0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         run_ff  <= run_in;
         wp_ff   <= wp_in;
         hs_ff   <= hs_in;
      end
   end

   // A buffer end returns the state to scanning at diff offset zero.
   `ASSERT_NEXT(a_end_resets, step_en && item.last_word,
                mode_ff == sidenc_pkg::MODE_SCAN && wp_ff == '0 && hs_ff == '0,
                "state not cleared after buffer end")

   // While an interval is open, every word is copied as the first result of its item.
   `ASSERT_NOW(a_open_copies, step_en && mode_ff != sidenc_pkg::MODE_SCAN,
               bundle.count != '0 && bundle.slot[0].kind == sidenc_pkg::KIND_DATA,
               "open interval did not copy its word")

endmodule

FILE: rtl/sparse_interval_diff_encoder_unit.sv
// Top level of the sparse interval diff encoder: handshakes and result bundle.
//
//   Channel | Direction | Handshake                 | Payload
//   req     | in        | req_tvalid / req_tready   | req_tdata, req_tlast
//   rsp     | out       | rsp_tvalid / rsp_tready   | rsp_tdata, rsp_tuser, rsp_tlast
//   csr     | in        | csr_valid / csr_ready     | csr_data (gap window)
//
// An item is registered on input, then processed combinationally into a bundle of
// zero to four results, which is loaded into the result register once that register
// is free; the first result is then offered. The result register sends one result
// per cycle while rsp_tready is high, and items with at most one result flow at one
// per cycle under the same condition. The input register takes one new item while
// results wait. Reset is synchronous, clears the interval state and returns the gap
// window to 32.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sparse_interval_diff_encoder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input items.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // word_index [19:0], new_word [51:20], old_word [83:52], zero pad [87:84]
   input  logic [sidenc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                  req_tlast,   // last_word
   // Result items.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // write_address [21:0], write_value [53:22], zero pad [55:54]
   output logic [sidenc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                            rsp_tuser,   // kind [1:0]
   output logic                                  rsp_tlast,   // last_of_item
   // Gap window register writes.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sidenc_pkg::GAP_W-1:0]          csr_data
);

   // Configuration register.
   logic [sidenc_pkg::GAP_W-1:0]                 gap_ff;

   // Input register.
   logic                                         in_valid_ff;
   sidenc_pkg::item_type                         item_ff;

   // Result bundle register.
   logic [sidenc_pkg::CNT_W-1:0]                 res_cnt_ff, res_cnt_in;
   logic [sidenc_pkg::POS_W-1:0]                 res_pos_ff, res_pos_in;
   sidenc_pkg::res_type [sidenc_pkg::MAX_RESULTS-1:0] slot_ff;

   sidenc_pkg::bundle_type                       bundle;
   sidenc_pkg::res_type                          cur;
   logic                                         rsp_take;
   logic                                         on_last;
   logic                                         bundle_free;
   logic                                         advance;

   // Gap window writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= sidenc_pkg::GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         gap_ff <= csr_data;
      end
   end

   // Handshake control between the input register and the result register.
   assign rsp_tvalid  = res_cnt_ff != '0;
   assign rsp_take    = rsp_tvalid && rsp_tready;
   assign on_last     = (sidenc_pkg::CNT_W'(res_pos_ff) + sidenc_pkg::CNT_W'(1)) == res_cnt_ff;
   assign bundle_free = (res_cnt_ff == '0) || (rsp_take && on_last);
   assign advance     = in_valid_ff && bundle_free;
   assign req_tready  = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.word_index <= req_tdata[19:0];
         item_ff.new_word   <= req_tdata[51:20];
         item_ff.old_word   <= req_tdata[83:52];
         item_ff.last_word  <= req_tlast;
      end
   end

   // Interval state and result computation.
   sidenc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .gap_window (gap_ff),
      .item       (item_ff),
      .bundle     (bundle)
   );

   // Result bundle bookkeeping.
   always_comb begin
      res_cnt_in = res_cnt_ff;
      res_pos_in = res_pos_ff;
      if (advance) begin
         res_cnt_in = bundle.count;
         res_pos_in = '0;
      end else if (rsp_take && on_last) begin
         res_cnt_in = '0;
         res_pos_in = '0;
      end else if (rsp_take) begin
         res_pos_in = res_pos_ff + sidenc_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_cnt_ff <= '0;
         res_pos_ff <= '0;
      end else begin
         res_cnt_ff <= res_cnt_in;
         res_pos_ff <= res_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= bundle.slot;
      end
   end

   // Output the current result of the bundle.
   assign cur       = slot_ff[res_pos_ff];
   assign rsp_tdata = {2'b00, cur.write_value, cur.write_address};
   assign rsp_tuser = cur.kind;
   assign rsp_tlast = on_last;

   // The read position always stays inside the held bundle.
   `ASSERT_NOW(a_pos_in_bundle, rsp_tvalid,
               sidenc_pkg::CNT_W'(res_pos_ff) < res_cnt_ff,
               "result position beyond bundle")

   // A bundle never holds more than four results.
   `ASSERT_NOW(a_cnt_bound, 1'b1,
               res_cnt_ff <= sidenc_pkg::CNT_W'(sidenc_pkg::MAX_RESULTS),
               "result bundle overfull")

   // A length report is the final result of its item and carries address zero.
   `ASSERT_NOW(a_length_last, rsp_tvalid && rsp_tuser == sidenc_pkg::KIND_LENGTH,
               rsp_tlast && rsp_tdata[21:0] == '0,
               "length report not last or nonzero address")

   // A held item that cannot move on blocks the input side.
   `ASSERT_NOW(a_hold_blocks, in_valid_ff && !bundle_free, !req_tready,
               "input accepted while held item is stalled")

endmodule

FILE: tb/sv/sidenc_checker.sv
// Checker for the sparse interval diff encoder: predicts each diff write and compares it.
`timescale 1ns / 1ps

module sidenc_checker import sidenc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // word_index [19:0], new_word [51:20], old_word [83:52], zero pad [87:84]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,   // last_word
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // write_address [21:0], write_value [53:22], zero pad [55:54]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]            rsp_tuser,   // kind [1:0]
   input  logic                  rsp_tlast,   // last_of_item
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [GAP_W-1:0]      csr_data,
   output int                    mismatch_count,
   output int                    pending_writes
);

   // One diff buffer write, header write or length report.
   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [WORD_W-1:0]   value;
      logic                last;
   } diff_write_type;

   // Encoder state as the predictor sees it.
   mode_type            enc_mode;
   logic [RUN_W-1:0]    quiet_run;
   logic [ADDR_W-1:0]   wr_ptr;
   logic [ADDR_W-1:0]   hdr_slot;
   logic [GAP_W-1:0]    gap_window;
   diff_write_type      expected_writes[$];

   initial begin
      mismatch_count = 0;
      pending_writes = 0;
   end

   function automatic void add_write(kind_type kind, logic [ADDR_W-1:0] address,
                                     logic [WORD_W-1:0] value);
      diff_write_type entry;
      entry.kind    = kind;
      entry.address = address;
      entry.value   = value;
      entry.last    = 1'b0;
      expected_writes.push_back(entry);
   endfunction

   function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Works out the writes that one accepted word causes and queues them in order.
   task automatic encode_word(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] nw,
                              input logic [WORD_W-1:0] ow, input logic last);
      logic               changed;
      logic               boundary;
      logic [WORD_W-1:0]  end_idx;
      int                 first;
      changed  = (nw != ow);
      boundary = (idx[BLOCK_BITS-1:0] == '1);
      end_idx  = WORD_W'(idx) + 1;
      first    = expected_writes.size();

      // Copy the word, opening an interval with a two-slot header where needed.
      if (enc_mode == MODE_SCAN) begin
         if (changed) begin
            hdr_slot = wr_ptr;
            wr_ptr   = hdr_slot + 2;
            add_write(KIND_DATA, wr_ptr, nw);
            wr_ptr   = wr_ptr + 1;
            add_write(KIND_HEADER, hdr_slot, WORD_W'(idx));
            quiet_run = '0;
            enc_mode  = MODE_OPEN;
         end
      end else begin
         add_write(KIND_DATA, wr_ptr, nw);
         wr_ptr = wr_ptr + 1;
         if (changed)
            quiet_run = '0;
         else if (quiet_run != '1)
            quiet_run = quiet_run + 1;
      end

      // Close at the end of the range and report its length, or at a block boundary after a long quiet run.
      if (last) begin
         if (enc_mode == MODE_OPEN) begin
            add_write(KIND_HEADER, hdr_slot + 1, end_idx);
         end else if (enc_mode == MODE_COPY) begin
            wr_ptr = wr_ptr - ADDR_W'(quiet_run);
            add_write(KIND_HEADER, hdr_slot + 1, end_idx - WORD_W'(quiet_run));
         end
         add_write(KIND_LENGTH, '0, WORD_W'(wr_ptr));
         enc_mode  = MODE_SCAN;
         quiet_run = '0;
         wr_ptr    = '0;
         hdr_slot  = '0;
      end else if (boundary) begin
         if (enc_mode == MODE_OPEN) begin
            enc_mode = MODE_COPY;
         end else if (enc_mode == MODE_COPY && quiet_run > RUN_W'(gap_window)) begin
            wr_ptr = wr_ptr - ADDR_W'(quiet_run);
            add_write(KIND_HEADER, hdr_slot + 1, end_idx - WORD_W'(quiet_run));
            enc_mode = MODE_SCAN;
         end
      end

      if (expected_writes.size() > first)
         expected_writes[expected_writes.size() - 1].last = 1'b1;
   endtask

   // Compare outgoing items first, then account for this edge's register write and word.
   always @(posedge clock) begin
      diff_write_type want;
      if (reset) begin
         enc_mode   = MODE_SCAN;
         quiet_run  = '0;
         wr_ptr     = '0;
         hdr_slot   = '0;
         gap_window = GAP_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_writes.size() == 0) begin
               $error("unexpected result item: kind %0d, address 0x%0h, value 0x%0h",
                      rsp_tuser, rsp_tdata[ADDR_W-1:0], rsp_tdata[ADDR_W +: WORD_W]);
               mismatch_count++;
            end else begin
               want = expected_writes.pop_front();
               check_field("kind", WORD_W'(want.kind), WORD_W'(rsp_tuser));
               check_field("write_address", WORD_W'(want.address),
                           WORD_W'(rsp_tdata[ADDR_W-1:0]));
               check_field("write_value", want.value, rsp_tdata[ADDR_W +: WORD_W]);
               check_field("last_of_item", WORD_W'(want.last), WORD_W'(rsp_tlast));
            end
         end
         if (csr_valid && csr_ready)
            gap_window = csr_data;
         if (req_tvalid && req_tready)
            encode_word(req_tdata[INDEX_W-1:0], req_tdata[INDEX_W +: WORD_W],
                        req_tdata[INDEX_W + WORD_W +: WORD_W], req_tlast);
      end
      pending_writes = expected_writes.size();
   end

endmodule

FILE: tb/sv/tb_sparse_interval_diff_encoder_unit.sv
// Testbench top for the sparse interval diff encoder: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_sparse_interval_diff_encoder_unit;
   import sidenc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_WORDS   = 32;
   localparam int SETTLE_CYCLES = 8;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [GAP_W-1:0]      csr_data   = '0;

   int mismatch_count;
   int pending_writes;
   int cycle_count = 0;
   int words_sent  = 0;
   bit req_calm    = 1'b0;
   bit rsp_calm    = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sparse_interval_diff_encoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   sidenc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_writes (pending_writes)
   );

   // Watchdog on the total run length.
   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Idle cycles before the next item; calm stretches run with no idling at all.
   function automatic int pick_pause(ref bit calm);
      if ($urandom_range(0, 31) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   // Result side: stall a random number of cycles before each item.
   initial begin
      int stall;
      forever begin
         stall = pick_pause(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Present one word and hold it until it is taken.
   task automatic send_word(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] nw,
                            input logic [WORD_W-1:0] ow, input logic last);
      int pause;
      pause = pick_pause(req_calm);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, ow, nw, idx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // A word with random content, changed against its base copy or not.
   task automatic send_random_word(input logic [INDEX_W-1:0] idx, input logic last,
                                   input bit changed);
      logic [WORD_W-1:0] nw;
      logic [WORD_W-1:0] flip;
      nw   = $urandom;
      flip = $urandom;
      if (flip == 0)
         flip = 1;
      send_word(idx, nw, changed ? nw ^ flip : nw, last);
   endtask

   // A well-formed range of whole blocks, sometimes cut short inside its final block.
   task automatic send_range(input logic [INDEX_W-1:0] base, input int blocks, input bit cut);
      int total;
      bit busy_block;
      total = blocks * 16;
      if (cut)
         total -= $urandom_range(1, 15);
      for (int k = 0; k < total; k++) begin
         if (k % 16 == 0)
            busy_block = $urandom_range(0, 1);
         send_random_word(INDEX_W'(base + k), k == total - 1,
                          busy_block && $urandom_range(0, 3) == 0);
      end
   endtask

   // Mostly well-formed ranges, with a few stray words mixed in.
   task automatic run_phase(input int budget);
      int stop;
      stop = words_sent + budget;
      while (words_sent < stop) begin
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 6))
               send_random_word(INDEX_W'($urandom), $urandom_range(0, 2) == 0,
                                $urandom_range(0, 1));
         else
            send_range({16'($urandom_range(0, 65535)), 4'b0},
                       $urandom_range(0, 5) == 0 ? $urandom_range(5, 8) : $urandom_range(1, 4),
                       $urandom_range(0, 4) == 0);
      end
   endtask

   // Stop sending, wait for every expected item, then let the block go quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_writes != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap(input logic [GAP_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Main sequence: directed words, then random phases under several gap windows.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A range that opens at its first word and ends mid-block.
      send_word(20'h00000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_word(20'h00001, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b0);
      send_word(20'h00002, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // The top index opens and ends an interval in one word.
      send_word(20'hFFFFE, 32'h0000_1234, 32'h0000_1234, 1'b0);
      send_word(20'hFFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      // A range with no change reports only its length.
      send_word(20'h12345, 32'h0000_0000, 32'h0000_0000, 1'b1);
      // Opening on a block boundary, then out-of-order indexes make the end index wrap.
      send_word(20'h0004F, 32'hCAFE_0001, 32'h0000_0000, 1'b0);
      repeat (3) send_word(20'h00000, 32'h0000_0077, 32'h0000_0077, 1'b0);
      send_word(20'h00000, 32'h0000_0077, 32'h0000_0077, 1'b1);

      run_phase(PHASE_WORDS);
      write_gap(16'h0000);
      run_phase(PHASE_WORDS);
      write_gap(16'hFFFF);
      run_phase(PHASE_WORDS);
      write_gap(GAP_W'($urandom_range(1, 24)));
      run_phase(PHASE_WORDS);
      write_gap(GAP_W'($urandom));
      run_phase(PHASE_WORDS);
      write_gap(16'd3);
      run_phase(PHASE_WORDS);
      settle();

      if (mismatch_count == 0 && pending_writes == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sparse_interval_diff_encoder_unit.f
+incdir+rtl
rtl/sidenc_pkg.sv
rtl/sidenc_core.sv
rtl/sparse_interval_diff_encoder_unit.sv
tb/sv/sidenc_checker.sv
tb/sv/tb_sparse_interval_diff_encoder_unit.sv
